// ===== rtl/smu_pkg.sv =====
// Shared types and constants for the SGD momentum update engine.
`default_nettype none
package smu_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DMUL,
      S_DDEN,
      S_DIV,
      S_MUL,
      S_RND,
      S_ADD,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CSR_INITIAL_RATE  = 2'd0,
      CSR_MOMENTUM_GAIN = 2'd1,
      CSR_RATE_DECAY    = 2'd2,
      CSR_NESTEROV_MODE = 2'd3
   } csr_index_type;

   localparam logic        KIND_INTERIM  = 1'b0;
   localparam logic        KIND_GRADIENT = 1'b1;
   localparam logic [30:0] RATE_RESET    = 31'd167772;
   localparam logic [63:0] HALF_Q24      = 64'd8388608;
   localparam logic [57:0] ONE_Q24       = 58'd16777216;
   localparam logic [5:0]  DIV_STEPS     = 6'd55;

endpackage
`default_nettype wire

// ===== rtl/smu_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module smu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic      [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/sgd_momentum_update.sv =====
// Top level: per-parameter SGD step engine with momentum and Nesterov ordering.
// Flow: accept, S_READ, S_MUL, S_RND, then S_ADD with momentum on a gradient beat, then S_DONE
//   and rsp_tvalid; an interim beat without momentum skips S_RND. A gradient batch start with decay
//   first runs S_DMUL, S_DDEN and S_DIV (multiply, denominator, 55-step divider).
// Throughput: one beat at a time through one shared 32x32 multiplier; next beat is taken
//   the cycle after the result is loaded into the output register, at the earliest.
// Reset: velocity memory is cleared one entry a cycle over all PARAM_COUNT entries,
//   with req_tready low meanwhile; rate reloads to RATE_RESET, count clears.
`default_nettype none
module sgd_momentum_update #(
   parameter int PARAM_COUNT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // param_index[11:0], gradient[43:12], zero pad
   input  wire logic [1:0]  req_tuser,   // kind[0], batch_start[1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // out_index[11:0], delta[43:12], zero pad
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);
   localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

   smu_pkg::state_type state_ff, state_in;

   // configuration
   logic [24:0] gain_ff, decay_ff;
   logic        nest_ff;
   logic [30:0] rate_ff, rate_in;
   logic [31:0] count_ff, count_in;

   // item
   logic        kind_ff, bstart_ff;
   logic [11:0] idx_ff;
   logic [31:0] grad_ff;
   logic        idx_ok;

   // datapath
   logic [31:0] v_ff, v_in;
   logic [31:0] v_rd;
   logic [31:0] res_ff, res_in;
   logic [31:0] delta_ff, delta_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;
   logic [57:0] den_ff, den_in;
   logic [57:0] rem_ff, rem_in;
   logic [54:0] quo_ff, quo_in;
   logic [5:0]  step_ff, step_in;

   // clear pass
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   // output
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   // memory
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_addr;
   logic [31:0]   ram_wdata, ram_rdata;
   logic [AW+11:0] idx_ext;

   logic        mom;
   logic [39:0] rnd;
   logic        rsign;
   logic [58:0] rem_sh;
   logic [32:0] sum;

   assign mom     = (gain_ff != 25'd0);
   assign idx_ext = (AW+12)'(idx_ff);
   assign ram_addr = idx_ext[AW-1:0];
   assign idx_ok  = (32'(idx_ff) < 32'(PARAM_COUNT));
   assign v_rd    = idx_ok ? ram_rdata : 32'd0;

   assign req_tready = (state_ff == smu_pkg::S_IDLE) && !clr_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   smu_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_vel (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      if (state_ff == smu_pkg::S_DMUL) begin
         mul_a = count_ff;
         mul_b = 32'(decay_ff);
      end else if (kind_ff == smu_pkg::KIND_GRADIENT) begin
         mul_a = grad_ff[31] ? (32'd0 - grad_ff) : grad_ff;
         mul_b = 32'(rate_ff);
      end else begin
         mul_a = v_rd[31] ? (32'd0 - v_rd) : v_rd;
         mul_b = 32'(gain_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      rate_in  = rate_ff;
      count_in = count_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      delta_in = delta_ff;
      prod_in  = prod_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      ram_we    = 1'b0;
      ram_waddr = ram_addr;
      ram_wdata = 32'd0;
      rnd    = 40'((prod_ff + smu_pkg::HALF_Q24) >> 24);
      rsign  = (kind_ff == smu_pkg::KIND_GRADIENT) ? !grad_ff[31] : v_ff[31];
      rem_sh = {rem_ff, quo_ff[54]};
      sum    = {v_ff[31], v_ff} + {res_ff[31], res_ff};

      if (clr_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
      end

      unique case (state_ff)
         smu_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = smu_pkg::S_READ;
            end
         end
         smu_pkg::S_READ: begin
            if (kind_ff == smu_pkg::KIND_GRADIENT && bstart_ff) begin
               if (decay_ff != 25'd0) begin
                  state_in = smu_pkg::S_DMUL;
               end else begin
                  count_in = count_ff + 32'd1;
                  state_in = smu_pkg::S_MUL;
               end
            end else begin
               state_in = smu_pkg::S_MUL;
            end
         end
         smu_pkg::S_DMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = smu_pkg::S_DDEN;
         end
         smu_pkg::S_DDEN: begin
            den_in   = smu_pkg::ONE_Q24 + prod_ff[57:0];
            rem_in   = 58'd0;
            quo_in   = {rate_ff, 24'd0};
            step_in  = smu_pkg::DIV_STEPS;
            state_in = smu_pkg::S_DIV;
         end
         smu_pkg::S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 58'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[53:0], 1'b1};
            end else begin
               rem_in = rem_sh[57:0];
               quo_in = {quo_ff[53:0], 1'b0};
            end
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               rate_in  = quo_in[30:0];
               count_in = count_ff + 32'd1;
               state_in = smu_pkg::S_MUL;
            end
         end
         smu_pkg::S_MUL: begin
            v_in    = v_rd;
            prod_in = mul_a * mul_b;
            if (kind_ff == smu_pkg::KIND_INTERIM && !mom) begin
               delta_in = 32'd0;
               state_in = smu_pkg::S_DONE;
            end else begin
               state_in = smu_pkg::S_RND;
            end
         end
         smu_pkg::S_RND: begin
            if (rsign) begin
               res_in = (rnd > 40'h0080000000) ? 32'h8000_0000 : 32'(40'd0 - rnd);
            end else begin
               res_in = (rnd > 40'h007FFFFFFF) ? 32'h7FFF_FFFF : rnd[31:0];
            end
            if (kind_ff == smu_pkg::KIND_INTERIM) begin
               ram_we    = idx_ok;
               ram_waddr = ram_addr;
               ram_wdata = res_in;
               delta_in  = nest_ff ? res_in : 32'd0;
               state_in  = smu_pkg::S_DONE;
            end else if (mom) begin
               state_in = smu_pkg::S_ADD;
            end else begin
               delta_in = res_in;
               state_in = smu_pkg::S_DONE;
            end
         end
         smu_pkg::S_ADD: begin
            if (sum[32] != sum[31]) begin
               v_in = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               v_in = sum[31:0];
            end
            ram_we    = idx_ok;
            ram_waddr = ram_addr;
            ram_wdata = v_in;
            delta_in  = nest_ff ? res_ff : v_in;
            state_in  = smu_pkg::S_DONE;
         end
         smu_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = smu_pkg::S_IDLE;
            end
         end
         default: state_in = smu_pkg::S_IDLE;
      endcase

      if (csr_we && csr_index == smu_pkg::CSR_INITIAL_RATE) begin
         rate_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smu_pkg::S_IDLE;
         gain_ff      <= 25'd0;
         decay_ff     <= 25'd0;
         nest_ff      <= 1'b0;
         rate_ff      <= smu_pkg::RATE_RESET;
         count_ff     <= 32'd0;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rate_ff  <= rate_in;
         count_ff <= count_in;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(PARAM_COUNT - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               // initial rate goes straight into the running rate
               smu_pkg::CSR_INITIAL_RATE:  ;
               smu_pkg::CSR_MOMENTUM_GAIN: gain_ff      <= csr_wdata[24:0];
               smu_pkg::CSR_RATE_DECAY:    decay_ff     <= csr_wdata[24:0];
               smu_pkg::CSR_NESTEROV_MODE: nest_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == smu_pkg::S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      res_ff   <= res_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      if (req_tvalid && req_tready) begin
         kind_ff   <= req_tuser[0];
         bstart_ff <= req_tuser[1];
         idx_ff    <= req_tdata[11:0];
         grad_ff   <= req_tdata[43:12];
      end
      if (state_ff == smu_pkg::S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {4'd0, delta_ff, idx_ff};
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a beat while still busy");

   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (state_ff == smu_pkg::S_IDLE))
      else $error("item in flight during clear pass");

   a_rate_not_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smu_pkg::S_DIV && step_ff == 6'd1 && !csr_we) |=>
         (rate_ff <= $past(rate_ff)))
      else $error("rate grew across decay");

   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smu_pkg::S_DIV) |-> (den_ff >= smu_pkg::ONE_Q24))
      else $error("divisor below one");

endmodule
`default_nettype wire
